// ===== hw/rtl/kscl_pkg.sv =====
// Shared package for the keypad scan code lock.
// Key map codes, field widths, reset code and the decoded-key struct.
// No dependencies.
package kscl_pkg;

  localparam int unsigned CODE_LENGTH_DEF = 11;
  localparam int unsigned COLS_W          = 4;
  localparam int unsigned ROWS_W          = 4;
  localparam int unsigned MAP_W           = 16;
  localparam int unsigned POS_W           = 4;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned CODE_W          = 44;
  localparam int unsigned CODE_DIGITS     = CODE_W / DIGIT_W;
  localparam int unsigned NUM_DIGIT_KEYS  = 10;

  localparam logic [CODE_W-1:0] SECRET_CODE_RST = 44'd9895609910086;

  localparam logic [MAP_W-1:0] KEY_CLEAR = 16'd4096;
  localparam logic [MAP_W-1:0] KEY_BACK  = 16'd8192;
  localparam logic [MAP_W-1:0] KEY_CHECK = 16'd32768;

  // map value of each digit key, indexed by digit
  localparam logic [MAP_W-1:0] DIGIT_KEYS [NUM_DIGIT_KEYS] = '{
    16'd8, 16'd4, 16'd64, 16'd1024, 16'd2,
    16'd32, 16'd512, 16'd1, 16'd16, 16'd256
  };

  typedef struct packed {
    logic               digit;
    logic [DIGIT_W-1:0] value;
    logic               clear;
    logic               back;
    logic               check;
  } key_act_t;

endpackage

// ===== hw/rtl/kscl_key_decode.sv =====
// Key map decoder for the keypad scan code lock.
// Maps an exact single-key map value to a key action; uses kscl_pkg.
module kscl_key_decode (
  input  logic [kscl_pkg::MAP_W-1:0] key_map,
  output kscl_pkg::key_act_t         act
);
  import kscl_pkg::*;

  always_comb begin
    act = '0;
    for (int unsigned i = 0; i < NUM_DIGIT_KEYS; i++) begin
      if (key_map == DIGIT_KEYS[i]) begin
        act.digit = 1'b1;
        act.value = DIGIT_W'(i);
      end
    end
    act.clear = (key_map == KEY_CLEAR);
    act.back  = (key_map == KEY_BACK);
    act.check = (key_map == KEY_CHECK);
  end

endmodule

// ===== hw/rtl/keypad_scan_code_lock_top.sv =====
// Top level of the keypad scan code lock.
// Holds scan, key map and entry state plus the result register; uses kscl_pkg
// and kscl_key_decode.
//
// One beat on the in_ channel is one scan tick. Its result appears in the
// output register the cycle after acceptance, and a new tick is taken every
// cycle: in_ready is high whenever the output register is empty or is being
// drained in the same cycle, so throughput is one tick per clock while the
// output is drained. Key map update, row advance, key decode, entry update
// and the full code compare are all done combinationally in the accepting
// cycle. The secret code is written through the cfg_ channel (always ready)
// and resets to the default code; the entry digits reset to zero directly.
module keypad_scan_code_lock_top #(
  parameter int unsigned CODE_LENGTH = kscl_pkg::CODE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kscl_pkg::CODE_W-1:0]   cfg_secret_code,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kscl_pkg::COLS_W-1:0]   in_column_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kscl_pkg::ROWS_W-1:0]   out_row_levels,
  output logic                          out_lock_led,
  output logic [kscl_pkg::POS_W-1:0]    out_entry_position,
  output logic [kscl_pkg::MAP_W-1:0]    out_key_map
);
  import kscl_pkg::*;

  localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH - 1);

  logic [CODE_W-1:0]  secret_code_r;
  logic [1:0]         scan_row_r, scan_row_nxt;
  logic [MAP_W-1:0]   map_r, map_nxt;
  logic               held_r, held_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DIGIT_W-1:0] digits_r [CODE_LENGTH];
  logic [ROWS_W-1:0]  row_r, row_nxt;
  logic               led_r, led_nxt;
  logic               out_valid_r;
  logic [ROWS_W-1:0]  out_row_r;
  logic               out_led_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [MAP_W-1:0]   out_map_r;

  key_act_t           act;
  logic               act_any;
  logic               in_fire;
  logic [CODE_LENGTH-1:0] digit_ok;
  logic               code_match;
  logic [POS_W-1:0]   back_pos;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // key map with the scanned row replaced by the inverted column levels
  always_comb begin
    map_nxt = map_r;
    map_nxt[{scan_row_r, 2'b00} +: COLS_W] = ~in_column_levels;
  end

  assign scan_row_nxt = scan_row_r + 2'd1;
  assign row_nxt = (row_r | (ROWS_W'(1) << scan_row_r)) & ~(ROWS_W'(1) << scan_row_nxt);

  kscl_key_decode u_decode (
    .key_map (map_nxt),
    .act     (act)
  );

  generate
    for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
      if (i < CODE_DIGITS) begin : g_code
        assign digit_ok[i] = (digits_r[i] == secret_code_r[i*DIGIT_W +: DIGIT_W]);
      end else begin : g_zero
        assign digit_ok[i] = (digits_r[i] == '0);
      end
    end
  endgenerate

  assign code_match = &digit_ok;
  assign act_any    = !held_r && (act.digit || act.clear || act.back || act.check);
  assign back_pos   = (pos_r == '0) ? LAST_POS : pos_r - POS_W'(1);

  always_comb begin
    pos_nxt = pos_r;
    led_nxt = led_r;
    if (!held_r) begin
      if (act.digit) begin
        pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + POS_W'(1);
      end else if (act.clear) begin
        pos_nxt = '0;
        led_nxt = 1'b0;
      end else if (act.back) begin
        pos_nxt = back_pos;
      end else if (act.check) begin
        led_nxt = code_match;
      end
    end
    held_nxt = (map_nxt == '0) ? 1'b0 : (held_r || act_any);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_code_r <= SECRET_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      secret_code_r <= cfg_secret_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
      map_r      <= '0;
      held_r     <= 1'b0;
      pos_r      <= '0;
      row_r      <= '0;
      led_r      <= 1'b0;
    end else if (in_fire) begin
      scan_row_r <= scan_row_nxt;
      map_r      <= map_nxt;
      held_r     <= held_nxt;
      pos_r      <= pos_nxt;
      row_r      <= row_nxt;
      led_r      <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
        digits_r[i] <= '0;
      end
    end else if (in_fire && !held_r) begin
      if (act.digit) begin
        digits_r[pos_r[IDX_W-1:0]] <= act.value;
      end else if (act.clear) begin
        for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
          digits_r[i] <= '0;
        end
      end else if (act.back) begin
        digits_r[back_pos[IDX_W-1:0]] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_row_r <= row_nxt;
      out_led_r <= led_nxt;
      out_pos_r <= pos_nxt;
      out_map_r <= map_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_levels     = out_row_r;
  assign out_lock_led       = out_led_r;
  assign out_entry_position = out_pos_r;
  assign out_key_map        = out_map_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("entry position out of range");

  a_scan_row_low: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> row_r[scan_row_r] == 1'b0)
    else $error("next scanned row must be driven low after a tick");

  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !held_r && act.clear |=> pos_r == '0 && !led_r && held_r)
    else $error("clear key did not reset entry");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && out_pos_r == pos_r && out_map_r == map_r)
    else $error("result beat does not match state");
`endif

endmodule
